// ===== design/tbthd_pkg.sv =====
// package for the two-button tap/hold decoder
// holds event codes, per-button state type and the per-button update function
// no dependencies
`default_nettype none

package tbthd_pkg;

   // event codes carried in a response
   localparam logic [2:0] EV_OPEN_AUTO     = 3'd0;
   localparam logic [2:0] EV_OPEN_HOLD     = 3'd1;
   localparam logic [2:0] EV_OPEN_RELEASE  = 3'd2;
   localparam logic [2:0] EV_CLOSE_AUTO    = 3'd3;
   localparam logic [2:0] EV_CLOSE_HOLD    = 3'd4;
   localparam logic [2:0] EV_CLOSE_RELEASE = 3'd5;
   localparam logic [2:0] EV_CONFLICT      = 3'd6;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned WINDOW_W   = 16;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd500;

   localparam int unsigned TIME_W = 32;

   // state kept for one button
   typedef struct packed {
      logic              prev;
      logic              pending;
      logic              manual;
      logic [TIME_W-1:0] first_time;
   } btn_type;

   // outcome of handling one button
   typedef struct packed {
      btn_type    me;
      btn_type    other;
      logic       emit;
      logic [2:0] code;
   } btn_step_type;

   // edge handling then age check for one button
   function automatic btn_step_type button_step(
      input btn_type               me,
      input btn_type               other,
      input logic                  level,
      input logic [TIME_W-1:0]     now,
      input logic [WINDOW_W-1:0]   window,
      input logic [2:0]            auto_code,
      input logic [2:0]            hold_code,
      input logic [2:0]            release_code
   );
      btn_step_type      r;
      logic [TIME_W-1:0] win_ext;
      logic [TIME_W-1:0] age;
      win_ext = {{(TIME_W-WINDOW_W){1'b0}}, window};
      r.me    = me;
      r.other = other;
      r.emit  = 1'b0;
      r.code  = auto_code;
      // rising edge
      if (level && !me.prev) begin
         if (other.pending || other.manual) begin
            r.code          = EV_CONFLICT;
            r.emit          = 1'b1;
            r.me.pending    = 1'b0;
            r.me.manual     = 1'b0;
            r.other.pending = 1'b0;
            r.other.manual  = 1'b0;
         end else if (me.manual) begin
            r.code       = release_code;
            r.emit       = 1'b1;
            r.me.manual  = 1'b0;
            r.me.pending = 1'b0;
         end else if (!me.pending) begin
            r.me.first_time = now;
            r.me.pending    = 1'b1;
         end else if ((now - me.first_time) <= win_ext) begin
            r.code       = hold_code;
            r.emit       = 1'b1;
            r.me.manual  = 1'b1;
            r.me.pending = 1'b0;
         end
      end
      // pending click that has aged out
      age = now - r.me.first_time;
      if (r.me.pending && !r.me.manual && (age > win_ext)) begin
         r.code       = auto_code;
         r.emit       = 1'b1;
         r.me.pending = 1'b0;
      end
      r.me.prev = level;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/tbthd_req_if.sv =====
// request channel interface: button levels and tick time
// depends on tbthd_pkg
`default_nettype none

interface tbthd_req_if
   import tbthd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              open_level;
   logic              close_level;
   logic [TIME_W-1:0] time_now;

   modport source (output valid, output open_level, output close_level, output time_now,
                   input ready);
   modport sink   (input valid, input open_level, input close_level, input time_now,
                   output ready);
endinterface

`default_nettype wire

// ===== design/tbthd_rsp_if.sv =====
// response channel interface: event code and last-event flag
// no dependencies besides the language
`default_nettype none

interface tbthd_rsp_if ();
   logic       valid;
   logic       ready;
   logic [2:0] event_code;
   logic       last_event;

   modport source (output valid, output event_code, output last_event, input ready);
   modport sink   (input valid, input event_code, input last_event, output ready);
endinterface

`default_nettype wire

// ===== design/two_button_tap_hold_decoder.sv =====
// latency: a request's first response is valid the cycle after acceptance
// throughput: one request per cycle while each gives at most one response and
//   rsp_chan.ready is high; a request with two responses stalls the next request
//   (two-entry response register, draining one response a cycle while ready)
// reset: synchronous, active high; clears button state, priming and the
//   response count, and sets window_ff to 500
// top level of the tap/hold decoder; uses tbthd_pkg, tbthd_req_if, tbthd_rsp_if
`default_nettype none

module two_button_tap_hold_decoder
   import tbthd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   tbthd_req_if.sink                  req_chan,
   tbthd_rsp_if.source                rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [WINDOW_W-1:0] window_ff;
   btn_type             open_ff, open_in;
   btn_type             close_ff, close_in;
   logic                primed_ff;
   logic [1:0]          count_ff, count_in;
   logic [2:0]          slot0_ff, slot0_in;
   logic [2:0]          slot1_ff, slot1_in;

   btn_step_type        open_step;
   btn_step_type        close_step;
   logic                req_fire;
   logic                rsp_fire;
   logic                csr_write;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[CSR_ADDR_W-1] ? '0
                     : {{(CSR_DATA_W-WINDOW_W){1'b0}}, window_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_write && !csr_paddr[CSR_ADDR_W-1]) begin
         window_ff <= csr_pwdata[WINDOW_W-1:0];
      end
   end

   // handshakes
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // open button first, then close on the updated state
   always_comb begin
      open_step  = button_step(open_ff, close_ff, req_chan.open_level, req_chan.time_now,
                               window_ff, EV_OPEN_AUTO, EV_OPEN_HOLD, EV_OPEN_RELEASE);
      close_step = button_step(open_step.other, open_step.me, req_chan.close_level,
                               req_chan.time_now, window_ff,
                               EV_CLOSE_AUTO, EV_CLOSE_HOLD, EV_CLOSE_RELEASE);
   end

   // next button state and response register contents
   always_comb begin
      open_in  = open_ff;
      close_in = close_ff;
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      // drain one response
      if (rsp_fire) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
      if (req_fire) begin
         if (!primed_ff) begin
            open_in.prev  = req_chan.open_level;
            close_in.prev = req_chan.close_level;
            count_in      = 2'd0;
         end else begin
            open_in  = close_step.other;
            close_in = close_step.me;
            count_in = {1'b0, open_step.emit} + {1'b0, close_step.emit};
            slot0_in = open_step.emit ? open_step.code : close_step.code;
            slot1_in = close_step.code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= '0;
         close_ff  <= '0;
         primed_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         open_ff  <= open_in;
         close_ff <= close_in;
         count_ff <= count_in;
         if (req_fire) begin
            primed_ff <= 1'b1;
         end
      end
   end

   // response payload needs no reset
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_chan.valid      = (count_ff != 2'd0);
   assign rsp_chan.event_code = slot0_ff;
   assign rsp_chan.last_event = (count_ff == 2'd1);

`ifndef SYNTHESIS
   // a conflict clears both buttons, so nothing can follow it
   a_conflict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.event_code == EV_CONFLICT) |-> rsp_chan.last_event)
      else $error("conflict response not marked last");

   // a button is never pending and in manual mode at once
   a_open_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(open_ff.pending && open_ff.manual))
      else $error("open button pending and manual together");

   a_close_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(close_ff.pending && close_ff.manual))
      else $error("close button pending and manual together");

   // no request taken while two responses wait
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !req_chan.ready)
      else $error("request accepted with full response register");

   // the priming request gives no response
   a_prime_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && !primed_ff |=> (count_ff == 2'd0))
      else $error("priming request produced a response");
`endif

endmodule

`default_nettype wire
